/* design/nws_pkg.sv */
// nws_pkg: shared types, register codes and exp table helpers for the neuron
// multiply-accumulate block. No dependencies; imported by the top level.

package nws_pkg;

   // configuration port
   localparam int CSR_IDX_BITS = 1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MODE = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BIAS = 1'b1;

   // activation select codes (code 3 behaves as exponential)
   typedef enum logic [1:0] {
      MODE_SIGN   = 2'd0,
      MODE_LINEAR = 2'd1,
      MODE_EXP    = 2'd2
   } act_mode_type;

   // exp table format: Q1.30 magnitudes
   localparam int EXP_Q    = 30;
   localparam int EXP_BITS = EXP_Q + 1;
   localparam longint unsigned EXP_ONE  = 64'd1 << EXP_Q;
   localparam longint unsigned EXP_HALF = 64'd1 << (EXP_Q - 1);

   // side information carried along the activation pipeline
   typedef struct packed {
      logic signed [15:0] alt_value;  // sign step or linear result
      logic               alt_sat;    // linear clip flag
      logic               use_exp;    // take the table result instead
      logic               negative;   // rounded sum below zero
   } res_ctl_type;

   // exp(-h) from a 15-term Taylor series, each term truncated
   function automatic logic [EXP_BITS-1:0] exp_step_ratio(input longint unsigned h);
      longint unsigned t;
      longint          r;
      t = EXP_ONE;
      r = longint'(EXP_ONE);
      t = ((t * h) >> EXP_Q) / 1;   r = r - longint'(t);
      t = ((t * h) >> EXP_Q) / 2;   r = r + longint'(t);
      t = ((t * h) >> EXP_Q) / 3;   r = r - longint'(t);
      t = ((t * h) >> EXP_Q) / 4;   r = r + longint'(t);
      t = ((t * h) >> EXP_Q) / 5;   r = r - longint'(t);
      t = ((t * h) >> EXP_Q) / 6;   r = r + longint'(t);
      t = ((t * h) >> EXP_Q) / 7;   r = r - longint'(t);
      t = ((t * h) >> EXP_Q) / 8;   r = r + longint'(t);
      t = ((t * h) >> EXP_Q) / 9;   r = r - longint'(t);
      t = ((t * h) >> EXP_Q) / 10;  r = r + longint'(t);
      t = ((t * h) >> EXP_Q) / 11;  r = r - longint'(t);
      t = ((t * h) >> EXP_Q) / 12;  r = r + longint'(t);
      t = ((t * h) >> EXP_Q) / 13;  r = r - longint'(t);
      t = ((t * h) >> EXP_Q) / 14;  r = r + longint'(t);
      return EXP_BITS'(r);
   endfunction

   // table sample n: repeated product by the step ratio, rounded half up
   function automatic logic [EXP_BITS-1:0] exp_sample(input longint unsigned ratio,
                                                      input int n);
      longint unsigned v;
      v = EXP_ONE;
      for (int k = 0; k < n; k++) begin
         v = (v * ratio + EXP_HALF) >> EXP_Q;
      end
      return EXP_BITS'(v);
   endfunction

endpackage

/* design/neuron_weighted_sum_activation.sv */
// neuron_weighted_sum_activation: one neuron, multiply-accumulate into a RAM-held
// accumulator, then bias, rounding and activation. Depends on nws_pkg, nws_ram.
//
//   channel   | dir | handshake           | payload
//   ----------+-----+---------------------+-------------------------------------
//   req_      | in  | req_tvalid/tready   | tdata: activation_in, weight_in; tlast
//   rsp_      | out | rsp_tvalid/tready   | tdata: neuron_out; tuser: saturated
//   csr_      | in  | csr_wr_en           | csr_index, csr_wr_data
//
// One request per cycle unless stalled. The accumulator lives in a one-entry RAM
// read every cycle; a write-back forwarding register covers back-to-back requests.
// After its last request, a result passes multiply, accumulate, bias, round,
// clamp, index, table read, interpolate and the output register in order.
// Synchronous reset sets exp mode, zeroes bias, clears all valid bits.
// The pipeline stalls only while a held result blocks one in the last stage.

module neuron_weighted_sum_activation #(
   parameter int FRAC_BITS         = 12,
   parameter int ACC_BITS          = 40,
   parameter int EXP_TABLE_ENTRIES = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [31:0]                       req_tdata,   // activation_in, weight_in
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,   // neuron_out
   output logic                              rsp_tuser,   // saturated
   input  logic                              csr_wr_en,
   input  logic [nws_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [15:0]                       csr_wr_data
);

   import nws_pkg::*;

   localparam int XW     = ACC_BITS + 1 - FRAC_BITS;      // rounded sum width
   localparam int LW     = FRAC_BITS + 3;                 // in-range magnitude width
   localparam int DW     = FRAC_BITS + 4;
   localparam int CW     = (XW > DW) ? XW : DW;           // compare width
   localparam int IDX_W  = $clog2(EXP_TABLE_ENTRIES + 1);
   localparam int NUM_W  = LW + IDX_W;
   localparam int PW     = EXP_BITS + LW;
   localparam int EXP_LIM = 8 << FRAC_BITS;
   localparam longint unsigned EXP_H = (64'd8 << EXP_Q) / EXP_TABLE_ENTRIES;
   localparam logic [EXP_BITS-1:0] EXP_R = exp_step_ratio(EXP_H);
   localparam logic signed [15:0] ONE_POS =
      (FRAC_BITS >= 15) ? 16'sh7fff : 16'(1 << FRAC_BITS);
   localparam logic signed [15:0] ONE_NEG =
      (FRAC_BITS >= 15) ? 16'sh8000 : 16'(-(1 << FRAC_BITS));
   localparam logic ACC_ADDR = 1'b0;

   // ---------------------------------------------------------------------
   // exp(-t) table, constant
   logic [EXP_BITS-1:0] exp_rom [0:EXP_TABLE_ENTRIES];

   for (genvar gi = 0; gi <= EXP_TABLE_ENTRIES; gi++) begin : g_rom
      assign exp_rom[gi] = exp_sample(64'(EXP_R), gi);
   end

   // ---------------------------------------------------------------------
   // configuration registers
   logic [1:0]         mode_ff, mode_in;
   logic signed [15:0] bias_ff, bias_in;

   always_comb begin
      mode_in = mode_ff;
      bias_in = bias_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MODE: mode_in = csr_wr_data[1:0];
            CSR_BIAS: bias_in = csr_wr_data;
            default:  ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // pipeline control
   logic stall;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;
   logic rsp_valid_ff, rsp_valid_in;

   assign stall      = rsp_valid_ff && !rsp_tready && v8_ff;
   assign req_tready = !stall;

   // ---------------------------------------------------------------------
   // stage 1: product
   logic signed [31:0] prod1_ff, prod1_in;
   logic               last1_ff;

   assign prod1_in = $signed(req_tdata[15:0]) * $signed(req_tdata[31:16]);

   // ---------------------------------------------------------------------
   // accumulator store: read every cycle, forward the last write-back
   logic                       acc_wr_en;
   logic [ACC_BITS-1:0]        acc_wr_data;
   logic [ACC_BITS-1:0]        acc_rd_data;
   logic                       acc_vld_ff;
   logic                       fwd_vld_ff;
   logic [ACC_BITS-1:0]        fwd_data_ff;
   logic signed [ACC_BITS-1:0] acc_cur;
   logic signed [ACC_BITS:0]   acc_wide;
   logic signed [ACC_BITS-1:0] acc_sum;

   nws_ram #(
      .WIDTH (ACC_BITS),
      .DEPTH (1)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_wr_en),
      .wr_addr (ACC_ADDR),
      .wr_data (acc_wr_data),
      .rd_addr (ACC_ADDR),
      .rd_data (acc_rd_data)
   );

   always_comb begin
      if (fwd_vld_ff) begin
         acc_cur = fwd_data_ff;
      end else if (acc_vld_ff) begin
         acc_cur = acc_rd_data;
      end else begin
         acc_cur = '0;
      end
      acc_wide = (ACC_BITS + 1)'(acc_cur) + (ACC_BITS + 1)'(prod1_ff);
      // saturate to the accumulator range
      if (acc_wide[ACC_BITS] != acc_wide[ACC_BITS-1]) begin
         acc_sum = acc_wide[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                      : {1'b0, {(ACC_BITS-1){1'b1}}};
      end else begin
         acc_sum = acc_wide[ACC_BITS-1:0];
      end
   end

   // last term restarts the sum
   assign acc_wr_en   = v1_ff && !stall;
   assign acc_wr_data = last1_ff ? '0 : acc_sum;

   // ---------------------------------------------------------------------
   // stage 2 -> 3: add the bias
   logic signed [ACC_BITS-1:0] sum2_ff;
   logic signed [ACC_BITS:0]   tot_wide;
   logic signed [ACC_BITS-1:0] total3_ff, total3_in;

   always_comb begin
      tot_wide = (ACC_BITS + 1)'(sum2_ff)
               + ((ACC_BITS + 1)'(bias_ff) <<< FRAC_BITS);
      if (tot_wide[ACC_BITS] != tot_wide[ACC_BITS-1]) begin
         total3_in = tot_wide[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                        : {1'b0, {(ACC_BITS-1){1'b1}}};
      end else begin
         total3_in = tot_wide[ACC_BITS-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // stage 3 -> 4: round half up to FRAC_BITS
   logic signed [ACC_BITS:0] rnd_wide;
   logic signed [XW-1:0]     x4_ff, x4_in;
   logic                     tneg4_ff;

   assign rnd_wide = (ACC_BITS + 1)'(total3_ff)
                   + (ACC_BITS + 1)'(1 << (FRAC_BITS - 1));
   assign x4_in    = XW'(rnd_wide >>> FRAC_BITS);

   // ---------------------------------------------------------------------
   // stage 4 -> 5: magnitude, range check, sign step and linear results
   logic                 xneg;
   logic [XW-1:0]        ax_d;
   logic [CW-1:0]        ax_c;
   logic                 big5_ff, big5_in;
   logic [LW-1:0]        ax5_ff, ax5_in;
   res_ctl_type          ctl5_ff, ctl5_in;
   logic signed [15:0]   lin_val;
   logic                 lin_sat;

   always_comb begin
      xneg    = x4_ff[XW-1];
      ax_d    = xneg ? XW'(-x4_ff) : XW'(x4_ff);
      ax_c    = CW'(ax_d);
      big5_in = ax_c >= CW'(EXP_LIM);
      ax5_in  = ax_c[LW-1:0];

      // linear clip to 16 bits
      if (x4_ff > $signed(XW'(32767))) begin
         lin_val = 16'sh7fff;
         lin_sat = 1'b1;
      end else if (x4_ff < -$signed(XW'(32768))) begin
         lin_val = 16'sh8000;
         lin_sat = 1'b1;
      end else begin
         lin_val = x4_ff[15:0];
         lin_sat = 1'b0;
      end

      ctl5_in.negative = xneg;
      case (mode_ff)
         MODE_SIGN: begin
            ctl5_in.alt_value = tneg4_ff ? ONE_NEG : ONE_POS;
            ctl5_in.alt_sat   = 1'b0;
            ctl5_in.use_exp   = 1'b0;
         end
         MODE_LINEAR: begin
            ctl5_in.alt_value = lin_val;
            ctl5_in.alt_sat   = lin_sat;
            ctl5_in.use_exp   = 1'b0;
         end
         default: begin
            ctl5_in.alt_value = '0;
            ctl5_in.alt_sat   = 1'b0;
            ctl5_in.use_exp   = 1'b1;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // stage 5 -> 6: table index and interpolation remainder
   logic [NUM_W-1:0] num;
   logic [IDX_W-1:0] idx6_ff, idx6_in;
   logic [IDX_W-1:0] nxt6_ff, nxt6_in;
   logic [LW-1:0]    rem6_ff, rem6_in;
   res_ctl_type      ctl6_ff;

   always_comb begin
      num = NUM_W'(ax5_ff) * NUM_W'(EXP_TABLE_ENTRIES);
      if (big5_ff) begin
         // beyond the table: last sample, no correction
         idx6_in = IDX_W'(EXP_TABLE_ENTRIES);
         nxt6_in = IDX_W'(EXP_TABLE_ENTRIES);
         rem6_in = '0;
      end else begin
         idx6_in = num[NUM_W-1:LW];
         nxt6_in = num[NUM_W-1:LW] + 1'b1;
         rem6_in = num[LW-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // stage 6 -> 7: table read
   logic [EXP_BITS-1:0] e0_7_ff, e1_7_ff;
   logic [LW-1:0]       rem7_ff;
   res_ctl_type         ctl7_ff;

   // ---------------------------------------------------------------------
   // stage 7 -> 8: slope times remainder
   logic [EXP_BITS-1:0] diff7;
   logic [PW-1:0]       prod8_ff, prod8_in;
   logic [EXP_BITS-1:0] e0_8_ff;
   res_ctl_type         ctl8_ff;

   assign diff7    = e0_7_ff - e1_7_ff;
   assign prod8_in = PW'(diff7) * PW'(rem7_ff);

   // ---------------------------------------------------------------------
   // stage 8 -> output: 1 - exp(-|x|), round, clamp, sign, mode select
   logic [EXP_BITS-1:0] corr;
   logic [EXP_BITS-1:0] e_val;
   logic [EXP_BITS-1:0] one_minus;
   logic [31:0]         y_sum;
   logic [31:0]         y_q;
   logic [14:0]         y_mag;
   logic signed [15:0]  exp_val;
   logic [15:0]         rsp_data_ff, rsp_data_in;
   logic                rsp_sat_ff, rsp_sat_in;

   always_comb begin
      corr      = EXP_BITS'(prod8_ff >> LW);
      e_val     = e0_8_ff - corr;
      one_minus = EXP_BITS'(EXP_ONE) - e_val;
      y_sum     = 32'(one_minus) + 32'(1 << (EXP_Q - FRAC_BITS - 1));
      y_q       = y_sum >> (EXP_Q - FRAC_BITS);
      y_mag     = (y_q > 32'd32767) ? 15'h7fff : y_q[14:0];
      exp_val   = ctl8_ff.negative ? -$signed({1'b0, y_mag}) : $signed({1'b0, y_mag});

      if (ctl8_ff.use_exp) begin
         rsp_data_in = exp_val;
         rsp_sat_in  = 1'b0;
      end else begin
         rsp_data_in = ctl8_ff.alt_value;
         rsp_sat_in  = ctl8_ff.alt_sat;
      end

      if (v8_ff && !stall) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

   // ---------------------------------------------------------------------
   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_EXP;
         bias_ff      <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         v8_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_vld_ff   <= 1'b0;
         fwd_vld_ff   <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         bias_ff      <= bias_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_vld_ff   <= acc_wr_en;
         if (acc_wr_en) begin
            acc_vld_ff <= 1'b1;
         end
         if (!stall) begin
            v1_ff <= req_tvalid;
            v2_ff <= v1_ff && last1_ff;
            v3_ff <= v2_ff;
            v4_ff <= v3_ff;
            v5_ff <= v4_ff;
            v6_ff <= v5_ff;
            v7_ff <= v6_ff;
            v8_ff <= v7_ff;
         end
      end
   end

   // ---------------------------------------------------------------------
   // payload registers
   always_ff @(posedge clock) begin
      if (acc_wr_en) begin
         fwd_data_ff <= acc_wr_data;
      end
      if (!stall) begin
         prod1_ff  <= prod1_in;
         last1_ff  <= req_tlast;
         sum2_ff   <= acc_sum;
         total3_ff <= total3_in;
         x4_ff     <= x4_in;
         tneg4_ff  <= total3_ff[ACC_BITS-1];
         ax5_ff    <= ax5_in;
         big5_ff   <= big5_in;
         ctl5_ff   <= ctl5_in;
         idx6_ff   <= idx6_in;
         nxt6_ff   <= nxt6_in;
         rem6_ff   <= rem6_in;
         ctl6_ff   <= ctl5_ff;
         e0_7_ff   <= exp_rom[idx6_ff];
         e1_7_ff   <= exp_rom[nxt6_ff];
         rem7_ff   <= rem6_ff;
         ctl7_ff   <= ctl6_ff;
         prod8_ff  <= prod8_in;
         e0_8_ff   <= e0_7_ff;
         ctl8_ff   <= ctl7_ff;
      end
      if (v8_ff && !stall) begin
         rsp_data_ff <= rsp_data_in;
         rsp_sat_ff  <= rsp_sat_in;
      end
   end

endmodule

/* design/nws_ram.sv */
// nws_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies; used by the neuron top level for the accumulator store.

module nws_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];

   // write port, read-before-write on the read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
